FILE: hw/rtl/hlus_pkg.sv
// Shared types and constants for the histogram log-uniform sampler.
// Holds the controller command codes, the status bundle and the field codes.
// No dependencies.
`default_nettype none

package hlus_pkg;

    localparam int MAX_EDGES_DEF     = 256;
    localparam int ENERGY_BITS_DEF   = 48;
    localparam int WEIGHT_BITS_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 32;

    localparam int MODE_BITS   = 2;
    localparam int SUM_BITS    = 40;
    localparam int PICK_BITS   = 32;
    localparam int BIN_BITS    = 8;
    localparam int STATUS_BITS = 3;
    localparam int MANT_BITS   = 64;
    localparam int EXP_BITS    = 6;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_EDGE  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_DECREASING = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_READY  = 3'd4;

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NOP       = 5'd0;
    localparam cmd_t CMD_LOAD      = 5'd1;
    localparam cmd_t CMD_CLEAR     = 5'd2;
    localparam cmd_t CMD_APPEND    = 5'd3;
    localparam cmd_t CMD_ZERO_RES  = 5'd4;
    localparam cmd_t CMD_NOT_READY = 5'd5;
    localparam cmd_t CMD_RHS_LO    = 5'd6;
    localparam cmd_t CMD_RHS_HI    = 5'd7;
    localparam cmd_t CMD_SRCH_RD   = 5'd8;
    localparam cmd_t CMD_SRCH_CMP  = 5'd9;
    localparam cmd_t CMD_RD_LO     = 5'd10;
    localparam cmd_t CMD_RD_HI     = 5'd11;
    localparam cmd_t CMD_GOT_HI    = 5'd12;
    localparam cmd_t CMD_LOG_LO    = 5'd13;
    localparam cmd_t CMD_LOG_HI    = 5'd14;
    localparam cmd_t CMD_TGT_A     = 5'd15;
    localparam cmd_t CMD_TGT_B     = 5'd16;
    localparam cmd_t CMD_TGT_C     = 5'd17;
    localparam cmd_t CMD_EXP_MID   = 5'd18;
    localparam cmd_t CMD_LOG_MID   = 5'd19;
    localparam cmd_t CMD_EXP_UPD   = 5'd20;
    localparam cmd_t CMD_SAMPLE_OK = 5'd21;
    localparam cmd_t CMD_OUT_LOAD  = 5'd22;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 not_ready;
        logic                 srch_more;
        logic                 exp_more;
        logic                 log_done;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hlus_log2.sv
// Iterative fixed-point base-2 logarithm unit.
// Normalises in six shift steps, then squares the mantissa once per fraction bit
// on a single 32x32 multiplier. Depends on hlus_pkg.
`default_nettype none

module hlus_log2 #(
    parameter int ENERGY_BITS   = hlus_pkg::ENERGY_BITS_DEF,
    parameter int FRACTION_BITS = hlus_pkg::FRACTION_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [ENERGY_BITS-1:0]                    x,
    output logic                                      done,
    output logic [hlus_pkg::EXP_BITS+FRACTION_BITS-1:0] result
);
    import hlus_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS);

    localparam logic [2:0] L_IDLE   = 3'd0;
    localparam logic [2:0] L_NORM   = 3'd1;
    localparam logic [2:0] L_HALF   = 3'd2;
    localparam logic [2:0] L_SQ_HI  = 3'd3;
    localparam logic [2:0] L_SQ_MID = 3'd4;
    localparam logic [2:0] L_SQ_LO  = 3'd5;
    localparam logic [2:0] L_BIT    = 3'd6;

    logic [2:0]               lstate_reg;
    logic [MANT_BITS-1:0]     y_reg;
    logic [EXP_BITS-1:0]      e_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [2:0]               step_reg;
    logic [CNT_W-1:0]         bit_reg;
    logic [2*MANT_BITS-1:0]   acc_reg;
    logic                     done_reg;

    logic [6:0]               sh;
    logic                     top_zero;
    logic [31:0]              ma;
    logic [31:0]              mb;
    logic [63:0]              mul_p;
    logic [MANT_BITS-1:0]     ny;

    assign sh       = 7'd32 >> step_reg;
    assign top_zero = (y_reg >> (7'd64 - sh)) == '0;
    assign ny       = acc_reg[125:62];

    always_comb
    begin
        case (lstate_reg)
            L_SQ_HI:
            begin
                ma = y_reg[63:32];
                mb = y_reg[63:32];
            end
            L_SQ_MID:
            begin
                ma = y_reg[63:32];
                mb = y_reg[31:0];
            end
            default:
            begin
                ma = y_reg[31:0];
                mb = y_reg[31:0];
            end
        endcase
    end

    assign mul_p = 64'(ma) * 64'(mb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lstate_reg <= L_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (lstate_reg)
                L_IDLE:   if (start) lstate_reg <= L_NORM;
                L_NORM:   if (step_reg == 3'd5) lstate_reg <= L_HALF;
                L_HALF:   lstate_reg <= L_SQ_HI;
                L_SQ_HI:  lstate_reg <= L_SQ_MID;
                L_SQ_MID: lstate_reg <= L_SQ_LO;
                L_SQ_LO:  lstate_reg <= L_BIT;
                L_BIT:
                begin
                    if (bit_reg == CNT_W'(FRACTION_BITS - 1))
                    begin
                        lstate_reg <= L_IDLE;
                        done_reg   <= 1'b1;
                    end
                    else
                    begin
                        lstate_reg <= L_SQ_HI;
                    end
                end
                default:  lstate_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (lstate_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    y_reg    <= MANT_BITS'(x);
                    e_reg    <= '1;
                    step_reg <= '0;
                end
            end
            L_NORM:
            begin
                // Halve the shift each step; a zero top slice means the leading one is lower.
                if (top_zero)
                begin
                    y_reg <= y_reg << sh;
                    e_reg <= e_reg - EXP_BITS'(sh);
                end
                step_reg <= step_reg + 3'd1;
            end
            L_HALF:
            begin
                y_reg   <= y_reg >> 1;
                bit_reg <= '0;
            end
            L_SQ_HI:  acc_reg <= {mul_p, 64'd0};
            L_SQ_MID: acc_reg <= acc_reg + {31'd0, mul_p, 33'd0};
            L_SQ_LO:  acc_reg <= acc_reg + {64'd0, mul_p};
            L_BIT:
            begin
                frac_reg <= {frac_reg[FRACTION_BITS-2:0], ny[63]};
                y_reg    <= ny[63] ? (ny >> 1) : ny;
                bit_reg  <= bit_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/hlus_datapath.sv
// Datapath of the sampler: edge and cumulative memories, table state, the shared
// multiplier, the bin search, the log unit and the in-bin energy search.
// Depends on hlus_pkg and hlus_log2.
`default_nettype none

module hlus_datapath #(
    parameter int MAX_EDGES     = hlus_pkg::MAX_EDGES_DEF,
    parameter int ENERGY_BITS   = hlus_pkg::ENERGY_BITS_DEF,
    parameter int WEIGHT_BITS   = hlus_pkg::WEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = hlus_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hlus_pkg::cmd_t                   cmd,
    output hlus_pkg::dp_status_t             stat,
    input  logic [hlus_pkg::MODE_BITS-1:0]   mode,
    input  logic [ENERGY_BITS-1:0]           edge_energy,
    input  logic [WEIGHT_BITS-1:0]           bin_weight,
    input  logic [hlus_pkg::PICK_BITS-1:0]   uniform_pick,
    input  logic [hlus_pkg::PICK_BITS-1:0]   uniform_spread,
    output logic [ENERGY_BITS-1:0]           sampled_energy,
    output logic [hlus_pkg::BIN_BITS-1:0]    chosen_bin,
    output logic [hlus_pkg::STATUS_BITS-1:0] status
);
    import hlus_pkg::*;

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = ((WEIGHT_BITS > SUM_BITS) ? WEIGHT_BITS : SUM_BITS) + 1;
    localparam int LW = EXP_BITS + FRACTION_BITS;
    localparam int RW = SUM_BITS + PICK_BITS;

    logic [ENERGY_BITS-1:0] edge_mem [MAX_EDGES];
    logic [SUM_BITS-1:0]    cum_mem  [MAX_EDGES];

    logic [MODE_BITS-1:0]   mode_reg;
    logic [ENERGY_BITS-1:0] edge_in_reg;
    logic [WEIGHT_BITS-1:0] weight_in_reg;
    logic [PICK_BITS-1:0]   u1_reg;
    logic [PICK_BITS-1:0]   u2_reg;

    logic [CW-1:0]          count_reg;
    logic [SUM_BITS-1:0]    wsum_reg;
    logic [WEIGHT_BITS-1:0] lastw_reg;
    logic [ENERGY_BITS-1:0] prev_reg;

    logic [RW-1:0]          rhs_reg;
    logic [AW-1:0]          lo_idx_reg;
    logic [AW-1:0]          hi_idx_reg;
    logic [SUM_BITS-1:0]    cum_rd_reg;
    logic [ENERGY_BITS-1:0] edge_rd_reg;
    logic [ENERGY_BITS-1:0] lo_e_reg;
    logic [ENERGY_BITS-1:0] hi_e_reg;
    logic [LW-1:0]          lgl_reg;
    logic [95:0]            tgt_acc_reg;
    logic [LW-1:0]          target_reg;
    logic [ENERGY_BITS-1:0] a_reg;
    logic [ENERGY_BITS-1:0] b_reg;
    logic [ENERGY_BITS-1:0] mid_reg;

    logic [ENERGY_BITS-1:0] res_energy_reg;
    logic [BIN_BITS-1:0]    res_bin_reg;
    logic [STATUS_BITS-1:0] res_status_reg;
    logic [ENERGY_BITS-1:0] out_energy_reg;
    logic [BIN_BITS-1:0]    out_bin_reg;
    logic [STATUS_BITS-1:0] out_status_reg;

    logic [SW-1:0]          ws_ext;
    logic [SW-1:0]          lw_ext;
    logic [SW-1:0]          sum_ext;
    logic [SW-1:0]          diff_ext;
    logic [SUM_BITS-1:0]    total;
    logic [SUM_BITS-1:0]    sat_sum;
    logic                   edge_zero;
    logic                   edge_dec;
    logic                   table_full;
    logic                   append_ok;
    logic [AW:0]            idx_sum;
    logic [AW-1:0]          mid_idx;
    logic [AW-1:0]          rd_addr;
    logic                   pick_hit;
    logic [AW+BIN_BITS-1:0] pick_ext;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [LW-1:0]          ldiff;
    logic [63:0]            dlog;
    logic [ENERGY_BITS-1:0] span;
    logic                   log_start;
    logic [ENERGY_BITS-1:0] log_x;
    logic                   log_done;
    logic [LW-1:0]          log_res;

    assign ws_ext   = SW'(wsum_reg);
    assign lw_ext   = SW'(lastw_reg);
    assign sum_ext  = ws_ext + SW'(weight_in_reg);
    assign diff_ext = ws_ext - lw_ext;
    assign total    = (ws_ext >= lw_ext) ? diff_ext[SUM_BITS-1:0] : '0;
    assign sat_sum  = (sum_ext > SW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_BITS-1:0];

    assign edge_zero  = edge_in_reg == '0;
    assign edge_dec   = edge_in_reg < prev_reg;
    assign table_full = count_reg >= CW'(MAX_EDGES);
    assign append_ok  = !edge_zero && !edge_dec && !table_full;

    assign idx_sum  = {1'b0, lo_idx_reg} + {1'b0, hi_idx_reg};
    assign mid_idx  = idx_sum[AW:1];
    // The cumulative sums never fall, so the first bin reaching the pick is a binary search.
    assign pick_hit = {cum_rd_reg, 32'd0} >= rhs_reg;
    assign pick_ext = (AW + BIN_BITS)'(lo_idx_reg);

    always_comb
    begin
        case (cmd)
            CMD_SRCH_RD: rd_addr = mid_idx;
            CMD_RD_HI:   rd_addr = lo_idx_reg + AW'(1);
            default:     rd_addr = lo_idx_reg;
        endcase
    end

    assign ldiff = (log_res >= lgl_reg) ? (log_res - lgl_reg) : '0;
    assign dlog  = 64'(ldiff);
    assign span  = b_reg - a_reg;

    always_comb
    begin
        case (cmd)
            CMD_RHS_LO:
            begin
                mul_a = u1_reg;
                mul_b = total[31:0];
            end
            CMD_RHS_HI:
            begin
                mul_a = u1_reg;
                mul_b = 32'(total[SUM_BITS-1:32]);
            end
            CMD_TGT_A:
            begin
                mul_a = u2_reg;
                mul_b = dlog[31:0];
            end
            default:
            begin
                mul_a = u2_reg;
                mul_b = dlog[63:32];
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        case (cmd)
            CMD_LOG_LO: log_x = lo_e_reg;
            CMD_LOG_HI: log_x = hi_e_reg;
            default:    log_x = mid_reg;
        endcase
    end

    assign log_start = (cmd == CMD_LOG_LO) || (cmd == CMD_LOG_HI) || (cmd == CMD_LOG_MID);

    hlus_log2 #(
        .ENERGY_BITS   (ENERGY_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_APPEND && append_ok)
        begin
            edge_mem[count_reg[AW-1:0]] <= edge_in_reg;
            cum_mem[count_reg[AW-1:0]]  <= sat_sum;
        end
        edge_rd_reg <= edge_mem[rd_addr];
        cum_rd_reg  <= cum_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wsum_reg  <= '0;
            lastw_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd == CMD_CLEAR || (cmd == CMD_APPEND && !append_ok))
        begin
            count_reg <= '0;
            wsum_reg  <= '0;
            lastw_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd == CMD_APPEND)
        begin
            count_reg <= count_reg + CW'(1);
            wsum_reg  <= sat_sum;
            lastw_reg <= weight_in_reg;
            prev_reg  <= edge_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd) inside
            CMD_LOAD:
            begin
                mode_reg      <= mode;
                edge_in_reg   <= edge_energy;
                weight_in_reg <= bin_weight;
                u1_reg        <= uniform_pick;
                u2_reg        <= uniform_spread;
            end
            CMD_CLEAR, CMD_ZERO_RES:
            begin
                res_energy_reg <= '0;
                res_bin_reg    <= '0;
                res_status_reg <= STATUS_OK;
            end
            CMD_APPEND:
            begin
                res_energy_reg <= '0;
                res_bin_reg    <= '0;
                if (edge_zero)
                    res_status_reg <= STATUS_ZERO_EDGE;
                else if (edge_dec)
                    res_status_reg <= STATUS_DECREASING;
                else if (table_full)
                    res_status_reg <= STATUS_FULL;
                else
                    res_status_reg <= STATUS_OK;
            end
            CMD_NOT_READY:
            begin
                res_energy_reg <= '0;
                res_bin_reg    <= '0;
                res_status_reg <= STATUS_NOT_READY;
            end
            CMD_RHS_LO:
            begin
                rhs_reg    <= {8'd0, mul_p};
                lo_idx_reg <= '0;
                hi_idx_reg <= AW'(count_reg - CW'(2));
            end
            CMD_RHS_HI:   rhs_reg <= rhs_reg + {mul_p[39:0], 32'd0};
            CMD_SRCH_CMP:
            begin
                if (pick_hit)
                    hi_idx_reg <= mid_idx;
                else
                    lo_idx_reg <= mid_idx + AW'(1);
            end
            CMD_RD_HI:    lo_e_reg <= edge_rd_reg;
            CMD_GOT_HI:   hi_e_reg <= edge_rd_reg;
            CMD_LOG_HI:   lgl_reg <= log_res;
            CMD_TGT_A:    tgt_acc_reg <= {32'd0, mul_p};
            CMD_TGT_B:    tgt_acc_reg <= tgt_acc_reg + {mul_p, 32'd0};
            CMD_TGT_C:
            begin
                target_reg <= lgl_reg + LW'(tgt_acc_reg[95:32]);
                a_reg      <= lo_e_reg;
                b_reg      <= (hi_e_reg >= lo_e_reg) ? hi_e_reg : lo_e_reg;
            end
            CMD_EXP_MID:  mid_reg <= a_reg + (span >> 1) + ENERGY_BITS'(span[0]);
            CMD_EXP_UPD:
            begin
                if (log_res <= target_reg)
                    a_reg <= mid_reg;
                else
                    b_reg <= mid_reg - ENERGY_BITS'(1);
            end
            CMD_SAMPLE_OK:
            begin
                res_energy_reg <= a_reg;
                res_bin_reg    <= pick_ext[BIN_BITS-1:0];
                res_status_reg <= STATUS_OK;
            end
            CMD_OUT_LOAD:
            begin
                out_energy_reg <= res_energy_reg;
                out_bin_reg    <= res_bin_reg;
                out_status_reg <= res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.mode      = mode_reg;
    assign stat.not_ready = (count_reg < CW'(2)) || (total == '0);
    assign stat.srch_more = lo_idx_reg < hi_idx_reg;
    assign stat.exp_more  = a_reg < b_reg;
    assign stat.log_done  = log_done;

    assign sampled_energy = out_energy_reg;
    assign chosen_bin     = out_bin_reg;
    assign status         = out_status_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hlus_ctrl.sv
// Controller state machine of the sampler: sequences the datapath by commands
// and owns both handshakes. Depends on hlus_pkg.
`default_nettype none

module hlus_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output hlus_pkg::cmd_t       cmd,
    input  hlus_pkg::dp_status_t stat
);
    import hlus_pkg::*;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_DECODE    = 5'd1;
    localparam logic [4:0] ST_RHS_HI    = 5'd2;
    localparam logic [4:0] ST_SRCH      = 5'd3;
    localparam logic [4:0] ST_SRCH_CMP  = 5'd4;
    localparam logic [4:0] ST_RD_HI     = 5'd5;
    localparam logic [4:0] ST_GOT_HI    = 5'd6;
    localparam logic [4:0] ST_LOG_LO    = 5'd7;
    localparam logic [4:0] ST_WAIT_LO   = 5'd8;
    localparam logic [4:0] ST_LOG_HI    = 5'd9;
    localparam logic [4:0] ST_WAIT_HI   = 5'd10;
    localparam logic [4:0] ST_TGT_A     = 5'd11;
    localparam logic [4:0] ST_TGT_B     = 5'd12;
    localparam logic [4:0] ST_TGT_C     = 5'd13;
    localparam logic [4:0] ST_EXP       = 5'd14;
    localparam logic [4:0] ST_EXP_START = 5'd15;
    localparam logic [4:0] ST_EXP_WAIT  = 5'd16;
    localparam logic [4:0] ST_EXP_UPD   = 5'd17;
    localparam logic [4:0] ST_OUT       = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_OUT;
                unique case (stat.mode)
                    MODE_CLEAR:  cmd = CMD_CLEAR;
                    MODE_APPEND: cmd = CMD_APPEND;
                    MODE_SAMPLE:
                    begin
                        if (stat.not_ready)
                        begin
                            cmd = CMD_NOT_READY;
                        end
                        else
                        begin
                            cmd        = CMD_RHS_LO;
                            state_next = ST_RHS_HI;
                        end
                    end
                    default:     cmd = CMD_ZERO_RES;
                endcase
            end
            ST_RHS_HI:
            begin
                cmd        = CMD_RHS_HI;
                state_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                if (stat.srch_more)
                begin
                    cmd        = CMD_SRCH_RD;
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    cmd        = CMD_RD_LO;
                    state_next = ST_RD_HI;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd        = CMD_SRCH_CMP;
                state_next = ST_SRCH;
            end
            ST_RD_HI:
            begin
                cmd        = CMD_RD_HI;
                state_next = ST_GOT_HI;
            end
            ST_GOT_HI:
            begin
                cmd        = CMD_GOT_HI;
                state_next = ST_LOG_LO;
            end
            ST_LOG_LO:
            begin
                cmd        = CMD_LOG_LO;
                state_next = ST_WAIT_LO;
            end
            ST_WAIT_LO:  if (stat.log_done) state_next = ST_LOG_HI;
            ST_LOG_HI:
            begin
                cmd        = CMD_LOG_HI;
                state_next = ST_WAIT_HI;
            end
            ST_WAIT_HI:  if (stat.log_done) state_next = ST_TGT_A;
            ST_TGT_A:
            begin
                cmd        = CMD_TGT_A;
                state_next = ST_TGT_B;
            end
            ST_TGT_B:
            begin
                cmd        = CMD_TGT_B;
                state_next = ST_TGT_C;
            end
            ST_TGT_C:
            begin
                cmd        = CMD_TGT_C;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                if (stat.exp_more)
                begin
                    cmd        = CMD_EXP_MID;
                    state_next = ST_EXP_START;
                end
                else
                begin
                    cmd        = CMD_SAMPLE_OK;
                    state_next = ST_OUT;
                end
            end
            ST_EXP_START:
            begin
                cmd        = CMD_LOG_MID;
                state_next = ST_EXP_WAIT;
            end
            ST_EXP_WAIT: if (stat.log_done) state_next = ST_EXP_UPD;
            ST_EXP_UPD:
            begin
                cmd        = CMD_EXP_UPD;
                state_next = ST_EXP;
            end
            ST_OUT:
            begin
                // Wait until the output register is empty or being emptied this cycle.
                if (out_free)
                begin
                    cmd        = CMD_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd == CMD_OUT_LOAD)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/histogram_log_uniform_sampler.sv
// Histogram sampler with log-uniform spread inside the chosen bin. Each beat
// clears the table, appends one edge with its weight (a rejected edge clears
// the table), or draws one sample, and yields one result beat. A sample runs a
// binary search over the cumulative memory (one memory read port), then the
// iterative log2 unit, which squares the mantissa on one 32x32 multiplier; two
// calls give the bin edges and up to ENERGY_BITS more drive the in-bin energy
// search. One beat is in work at a time; a finished result waits in the
// output register while the next beat is taken. The memories need no
// clearing after reset.
// Depends on hlus_pkg, hlus_ctrl, hlus_datapath and hlus_log2.
`default_nettype none

module histogram_log_uniform_sampler #(
    parameter int MAX_EDGES     = hlus_pkg::MAX_EDGES_DEF,
    parameter int ENERGY_BITS   = hlus_pkg::ENERGY_BITS_DEF,
    parameter int WEIGHT_BITS   = hlus_pkg::WEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = hlus_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [hlus_pkg::MODE_BITS-1:0]   mode,
    input  logic [ENERGY_BITS-1:0]           edge_energy,
    input  logic [WEIGHT_BITS-1:0]           bin_weight,
    input  logic [hlus_pkg::PICK_BITS-1:0]   uniform_pick,
    input  logic [hlus_pkg::PICK_BITS-1:0]   uniform_spread,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [ENERGY_BITS-1:0]           sampled_energy,
    output logic [hlus_pkg::BIN_BITS-1:0]    chosen_bin,
    output logic [hlus_pkg::STATUS_BITS-1:0] status
);
    import hlus_pkg::*;

    cmd_t       cmd;
    dp_status_t stat;

    hlus_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    hlus_datapath #(
        .MAX_EDGES     (MAX_EDGES),
        .ENERGY_BITS   (ENERGY_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .mode           (mode),
        .edge_energy    (edge_energy),
        .bin_weight     (bin_weight),
        .uniform_pick   (uniform_pick),
        .uniform_spread (uniform_spread),
        .sampled_energy (sampled_energy),
        .chosen_bin     (chosen_bin),
        .status         (status)
    );

endmodule

`default_nettype wire
